@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset.
`define IRL_ASSERT_CK(lbl, ck, rstn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the local clk and rst_n.
`define IRL_ASSERT(lbl, prop, msg) \
    `IRL_ASSERT_CK(lbl, clk, rst_n, prop, msg)

`endif

@@ hw/rtl/irl_pkg.sv @@
// Shared types, constants and helpers of the interface route lookup block.
`default_nettype none

package irl_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IP_W        = 32;
    localparam int SLOT_W      = 3;

    localparam logic [IP_W-1:0] BCAST_ADDR = {IP_W{1'b1}};

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic            link;
        logic            up;
        logic            present;
        logic [IP_W-1:0] address;
        logic [IP_W-1:0] mask;
        logic [IP_W-1:0] gateway;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             clear;
        logic             vld;
        logic [IDX_W-1:0] slot;
        logic             slot_ok;
        logic [IP_W-1:0]  dest;
    } scan_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [IP_W-1:0]   hop;
    } result_t;

    function automatic logic [SLOT_W-1:0] slot_out(input logic [IDX_W-1:0] s);
        logic [IDX_W+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, s};
        return w[SLOT_W-1:0];
    endfunction

    function automatic logic idx_in_range(input logic [SLOT_W-1:0] i);
        logic [CNT_W+SLOT_W-1:0] w;
        w = {{CNT_W{1'b0}}, i};
        return w < (CNT_W + SLOT_W)'(TABLE_DEPTH);
    endfunction

    function automatic logic [IDX_W-1:0] idx_trunc(input logic [SLOT_W-1:0] i);
        logic [IDX_W+SLOT_W-1:0] w;
        w = {{IDX_W{1'b0}}, i};
        return w[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/irl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module irl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/irl_eval.sv @@
// Per-slot route qualification and first-hit tracking during a table walk.
`default_nettype none

module irl_eval (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire irl_pkg::scan_t    scan,
    input  wire irl_pkg::entry_t   rd_data,
    output irl_pkg::result_t       result
);
    import irl_pkg::*;

    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_slot_reg, hit_slot_next;
    logic [IP_W-1:0]  hit_hop_reg, hit_hop_next;
    logic             gw_reg, gw_next;
    logic [IDX_W-1:0] gw_slot_reg, gw_slot_next;
    logic [IP_W-1:0]  gw_hop_reg, gw_hop_next;

    logic is_bc;
    logic flags_ok;
    logic reach;
    logic sub_hit;
    logic gw_cand;

    always_comb
    begin
        is_bc    = (scan.dest == BCAST_ADDR);
        flags_ok = scan.slot_ok && rd_data.present && rd_data.up && rd_data.link;
        reach    = flags_ok && (rd_data.address != '0);
        sub_hit  = is_bc ? flags_ok
                         : (reach && (rd_data.mask != '0) &&
                            (((scan.dest ^ rd_data.address) & rd_data.mask) == '0));
        gw_cand  = !is_bc && reach && (rd_data.gateway != '0);

        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        hit_hop_next  = hit_hop_reg;
        gw_next       = gw_reg;
        gw_slot_next  = gw_slot_reg;
        gw_hop_next   = gw_hop_reg;

        if (scan.clear)
        begin
            hit_next = 1'b0;
            gw_next  = 1'b0;
        end
        else if (scan.vld)
        begin
            // keep only the lowest qualifying slot of each kind
            if (sub_hit && !hit_reg)
            begin
                hit_next      = 1'b1;
                hit_slot_next = scan.slot;
                hit_hop_next  = is_bc ? BCAST_ADDR : scan.dest;
            end
            if (gw_cand && !gw_reg)
            begin
                gw_next      = 1'b1;
                gw_slot_next = scan.slot;
                gw_hop_next  = rd_data.gateway;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            gw_reg  <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
            gw_reg  <= gw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_slot_reg <= hit_slot_next;
        hit_hop_reg  <= hit_hop_next;
        gw_slot_reg  <= gw_slot_next;
        gw_hop_reg   <= gw_hop_next;
    end

    always_comb
    begin
        result.found = hit_reg || gw_reg;
        if (hit_reg)
        begin
            result.slot = slot_out(hit_slot_reg);
            result.hop  = hit_hop_reg;
        end
        else if (gw_reg)
        begin
            result.slot = slot_out(gw_slot_reg);
            result.hop  = gw_hop_reg;
        end
        else
        begin
            result.slot = '0;
            result.hop  = '0;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/irl_ctrl.sv @@
// Request sequencer: table writes, slot walk and result register.
`default_nettype none

module irl_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic                          action,
    input  wire logic [irl_pkg::SLOT_W-1:0]    entry_index,
    input  wire logic                          entry_present,
    input  wire logic                          entry_up,
    input  wire logic                          entry_link,
    input  wire logic [irl_pkg::IP_W-1:0]      entry_address,
    input  wire logic [irl_pkg::IP_W-1:0]      entry_mask,
    input  wire logic [irl_pkg::IP_W-1:0]      entry_gateway,
    input  wire logic [irl_pkg::IP_W-1:0]      dest_addr,
    output logic                               ram_we,
    output logic [irl_pkg::IDX_W-1:0]          ram_waddr,
    output irl_pkg::entry_t                    ram_wdata,
    output logic [irl_pkg::IDX_W-1:0]          ram_raddr,
    output irl_pkg::scan_t                     scan,
    input  wire irl_pkg::result_t              result,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic                               found,
    output logic [irl_pkg::SLOT_W-1:0]         chosen_slot,
    output logic [irl_pkg::IP_W-1:0]           hop_addr
);
    import irl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       issue_cnt_reg, issue_cnt_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]       rd_slot_reg, rd_slot_next;
    logic [TABLE_DEPTH-1:0] slot_vld_reg, slot_vld_next;
    logic [IP_W-1:0]        dest_reg, dest_next;
    logic                   res_valid_reg, res_valid_next;
    result_t                res_reg, res_next;

    logic req_acc;
    logic wr_go;
    logic lk_go;
    logic all_issued;
    logic res_load;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_acc    = req_valid && !req_stall;
    assign wr_go      = req_acc && (action == ACT_WRITE) && idx_in_range(entry_index);
    assign lk_go      = req_acc && (action == ACT_LOOKUP);
    assign all_issued = (issue_cnt_reg == CNT_W'(TABLE_DEPTH));

    assign ram_we    = wr_go;
    assign ram_waddr = idx_trunc(entry_index);
    assign ram_raddr = issue_cnt_reg[IDX_W-1:0];

    always_comb
    begin
        ram_wdata.link    = entry_link;
        ram_wdata.up      = entry_up;
        ram_wdata.present = entry_present;
        ram_wdata.address = entry_address;
        ram_wdata.mask    = entry_mask;
        ram_wdata.gateway = entry_gateway;
    end

    always_comb
    begin
        scan.clear   = lk_go;
        scan.vld     = rd_pend_reg;
        scan.slot    = rd_slot_reg;
        scan.slot_ok = slot_vld_reg[rd_slot_reg];
        scan.dest    = dest_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_pend_next   = 1'b0;
        rd_slot_next   = ram_raddr;
        slot_vld_next  = slot_vld_reg;
        dest_next      = dest_reg;
        res_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (wr_go)
                begin
                    slot_vld_next[ram_waddr] = 1'b1;
                end
                if (lk_go)
                begin
                    dest_next      = dest_addr;
                    issue_cnt_next = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // one slot read per cycle; the last read returns as we leave
                if (all_issued)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_pend_next   = 1'b1;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid_next = res_load || (res_valid_reg && res_stall);
    assign res_next       = res_load ? result : res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
            slot_vld_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            slot_vld_reg  <= slot_vld_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_slot_next;
        dest_reg    <= dest_next;
        res_reg     <= res_next;
    end

    assign res_valid   = res_valid_reg;
    assign found       = res_reg.found;
    assign chosen_slot = res_reg.slot;
    assign hop_addr    = res_reg.hop;

endmodule

`default_nettype wire

@@ hw/rtl/interface_route_lookup_unit.sv @@
// Top level of the interface route lookup block.
// Keeps a table of TABLE_DEPTH interface slots (flags, address, mask, gateway)
// in one RAM with a single write port and a single registered read port.
// A write request (action = 0) fills one slot; an index at or beyond
// TABLE_DEPTH is dropped. A lookup request (action = 1) walks every slot
// through the read port, one slot per cycle, and yields one response:
// the lowest slot whose subnet holds the destination (or, for the broadcast
// address, the lowest present slot that is up with link), else the lowest
// addressable slot with a gateway, else not found. A lookup holds req_stall
// high from when it is taken until its walk over the single read port ends
// and its response is loaded, and longer while an earlier response still
// waits on res_stall, so a new lookup is not taken before the last one is
// through; write requests go back to back. The response sits in an output
// register, so the next request is taken while a response is still waiting
// on res_stall. Slot flags read as clear until a slot is first written,
// through per-slot valid flops cleared by reset; no clearing pass.
`default_nettype none

module interface_route_lookup_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire logic                       action,
    input  wire logic [irl_pkg::SLOT_W-1:0] entry_index,
    input  wire logic                       entry_present,
    input  wire logic                       entry_up,
    input  wire logic                       entry_link,
    input  wire logic [irl_pkg::IP_W-1:0]   entry_address,
    input  wire logic [irl_pkg::IP_W-1:0]   entry_mask,
    input  wire logic [irl_pkg::IP_W-1:0]   entry_gateway,
    input  wire logic [irl_pkg::IP_W-1:0]   dest_addr,
    output logic                            res_valid,
    input  wire logic                       res_stall,
    output logic                            found,
    output logic [irl_pkg::SLOT_W-1:0]      chosen_slot,
    output logic [irl_pkg::IP_W-1:0]        hop_addr
);
    import irl_pkg::*;

    // RAM port signals
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t           rd_entry;

    // walk control toward the evaluator and its running result
    scan_t   scan;
    result_t result;

    assign rd_entry = entry_t'(ram_rdata);

    irl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .action        (action),
        .entry_index   (entry_index),
        .entry_present (entry_present),
        .entry_up      (entry_up),
        .entry_link    (entry_link),
        .entry_address (entry_address),
        .entry_mask    (entry_mask),
        .entry_gateway (entry_gateway),
        .dest_addr     (dest_addr),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .scan          (scan),
        .result        (result),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .found         (found),
        .chosen_slot   (chosen_slot),
        .hop_addr      (hop_addr)
    );

    // slot table: one entry per interface
    irl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // qualify each returned slot and keep the first subnet and gateway hits
    irl_eval u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan    (scan),
        .rd_data (rd_entry),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ hw/rtl/irl_chk.sv @@
// Port-level checker for the interface route lookup block, with its bind.
`default_nettype none
`include "assert_macros.svh"

module irl_chk (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_stall,
    input wire logic                       action,
    input wire logic                       res_valid,
    input wire logic                       res_stall,
    input wire logic                       found,
    input wire logic [irl_pkg::SLOT_W-1:0] chosen_slot,
    input wire logic [irl_pkg::IP_W-1:0]   hop_addr
);
    import irl_pkg::*;

    logic [IP_W+SLOT_W-1:0] res_fields;
    logic [IP_W+SLOT_W+1:0] res_word;
    logic                   lk_acc;

    assign res_fields = {chosen_slot, hop_addr};
    assign res_word   = {res_valid, found, res_fields};
    assign lk_acc     = req_valid && !req_stall && (action == ACT_LOOKUP);

    // hold a stalled response
    `IRL_ASSERT(a_res_hold, res_valid && res_stall |=> $stable(res_word), "stalled response changed")

    // a miss reports slot zero and a zero next hop
    `IRL_ASSERT(a_miss_zero, res_valid && !found |-> (res_fields == '0), "miss with nonzero fields")

    // a taken lookup blocks the next request while the table is walked
    `IRL_ASSERT(a_lookup_busy, lk_acc |=> req_stall, "request taken during walk")

    // a new response only appears at the end of a walk
    `IRL_ASSERT(a_res_after_walk, $rose(res_valid) |-> $past(req_stall), "response without a walk")

endmodule

bind interface_route_lookup_unit irl_chk u_irl_chk (.*);

`default_nettype wire
